// File: src/prc_pkg.sv
// Shared types and constants for the polygon ring classifier.
`default_nettype none

package prc_pkg;

	localparam int XY_W             = 16;
	localparam int SUM_W            = XY_W + 1;
	localparam int PROD_W           = 2 * SUM_W;
	localparam int DELTA_W          = PROD_W + 1;
	localparam int AREA_W           = 45;
	localparam int POLY_W           = 8;
	localparam int MAX_POLYGONS_DEF = 256;

	localparam logic signed [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
	localparam logic signed [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

	localparam logic [1:0] SIGN_UNSET = 2'd0;
	localparam logic [1:0] SIGN_POS   = 2'd1;
	localparam logic [1:0] SIGN_NEG   = 2'd2;

	typedef struct packed {
		logic signed [XY_W-1:0] vx;
		logic signed [XY_W-1:0] vy;
		logic                   ring_end;
		logic                   feature_end;
	} vtx_t;

	typedef struct packed {
		logic signed [AREA_W-1:0] ring_area;
		logic                     ring_kept;
		logic                     starts_polygon;
		logic [POLY_W-1:0]        polygon_number;
		logic                     feature_done;
	} res_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] pair;
		logic signed [PROD_W-1:0] close;
		logic                     ring_start;
		logic                     ring_end;
		logic                     feature_end;
	} term_t;

endpackage

`default_nettype wire

// File: src/prc_ifs.sv
// Valid/ready channel interfaces for vertex and result beats.
`default_nettype none

interface prc_vtx_if;
	import prc_pkg::*;
	logic valid;
	logic ready;
	vtx_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface prc_res_if;
	import prc_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/prc_term_stage.sv
// Input register, ring vertex tracking and the two shoelace products.
`default_nettype none

module prc_term_stage (
	input  logic           clk,
	input  logic           arst_n,
	prc_vtx_if.sink        vertices,
	input  logic           take,
	output logic           term_valid,
	output prc_pkg::term_t term
);
	import prc_pkg::*;

	logic                   v_s1;
	vtx_t                   vtx_s1;
	logic                   v_s2;
	term_t                  term_s2;
	logic                   at_ring_start_q;
	logic signed [XY_W-1:0] first_x_q;
	logic signed [XY_W-1:0] first_y_q;
	logic signed [XY_W-1:0] prev_x_q;
	logic signed [XY_W-1:0] prev_y_q;

	logic                     adv1;
	logic signed [XY_W-1:0]   fx;
	logic signed [XY_W-1:0]   fy;
	logic signed [SUM_W-1:0]  dx_p;
	logic signed [SUM_W-1:0]  sy_p;
	logic signed [SUM_W-1:0]  dx_c;
	logic signed [SUM_W-1:0]  sy_c;
	logic signed [PROD_W-1:0] prod_p;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] pair;
	logic signed [PROD_W-1:0] close;

	assign adv1           = v_s1 && (!v_s2 || take);
	assign vertices.ready = !v_s1 || adv1;
	assign term_valid     = v_s2;
	assign term           = term_s2;

	always_comb begin
		fx     = at_ring_start_q ? vtx_s1.vx : first_x_q;
		fy     = at_ring_start_q ? vtx_s1.vy : first_y_q;
		dx_p   = SUM_W'(prev_x_q) - SUM_W'(vtx_s1.vx);
		sy_p   = SUM_W'(vtx_s1.vy) + SUM_W'(prev_y_q);
		dx_c   = SUM_W'(vtx_s1.vx) - SUM_W'(fx);
		sy_c   = SUM_W'(fy) + SUM_W'(vtx_s1.vy);
		prod_p = dx_p * sy_p;
		prod_c = dx_c * sy_c;
		pair   = at_ring_start_q ? '0 : prod_p;
		close  = vtx_s1.ring_end ? prod_c : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1            <= 1'b0;
			v_s2            <= 1'b0;
			at_ring_start_q <= 1'b1;
			first_x_q       <= '0;
			first_y_q       <= '0;
			prev_x_q        <= '0;
			prev_y_q        <= '0;
		end else begin
			if (vertices.ready) begin
				v_s1 <= vertices.valid;
			end
			if (adv1) begin
				v_s2            <= 1'b1;
				first_x_q       <= fx;
				first_y_q       <= fy;
				prev_x_q        <= vtx_s1.vx;
				prev_y_q        <= vtx_s1.vy;
				at_ring_start_q <= vtx_s1.ring_end;
			end else if (take) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vertices.valid && vertices.ready) begin
			vtx_s1 <= vertices.data;
		end
		if (adv1) begin
			term_s2.pair        <= pair;
			term_s2.close       <= close;
			term_s2.ring_start  <= at_ring_start_q;
			term_s2.ring_end    <= vtx_s1.ring_end;
			term_s2.feature_end <= vtx_s1.feature_end;
		end
	end

endmodule

`default_nettype wire

// File: src/polygon_ring_classifier.sv
// Top level: shoelace area accumulation, ring classification and result register.
// A ring's last vertex passes the input register, the term register and the result register before its result shows.
// Throughput: one vertex per cycle unless a waiting result beat stalls a ring's last vertex, set by the
// 17x17 product stage and the 46-bit saturating accumulate loop.
// With a result beat waiting, vertices flow until a ring's last one stalls at the accumulator.
// Reset (arst_n low, asynchronous): pipeline empty, ring and feature trackers at start.
`default_nettype none

module polygon_ring_classifier #(
	parameter int MAX_POLYGONS = prc_pkg::MAX_POLYGONS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	prc_vtx_if.sink   vertices,
	prc_res_if.source results
);
	import prc_pkg::*;

	localparam int               CAP   = (MAX_POLYGONS < 256) ? MAX_POLYGONS : 256;
	localparam logic [POLY_W:0]  CAP_W = (POLY_W+1)'(CAP);

	logic  term_valid;
	term_t term;
	logic  take;
	logic  out_free;

	logic signed [AREA_W-1:0] area_q;
	logic                     at_feature_start_q;
	logic [1:0]               outer_sign_q;
	logic [POLY_W-1:0]        poly_cnt_q;
	logic                     out_valid_q;
	res_t                     res_q;

	logic signed [DELTA_W-1:0] delta;
	logic signed [AREA_W-1:0]  base;
	logic signed [AREA_W:0]    sum;
	logic signed [AREA_W-1:0]  area;
	logic [1:0]                sign;
	logic                      kept;
	logic                      starts;
	logic [1:0]                outer_nx;
	logic [POLY_W-1:0]         poly_nx;
	logic [POLY_W-1:0]         num;

	prc_term_stage u_term (
		.clk        (clk),
		.arst_n     (arst_n),
		.vertices   (vertices),
		.take       (take),
		.term_valid (term_valid),
		.term       (term)
	);

	assign out_free      = !out_valid_q || results.ready;
	assign take          = term_valid && (!term.ring_end || out_free);
	assign results.valid = out_valid_q;
	assign results.data  = res_q;

	always_comb begin
		delta = DELTA_W'(term.pair) + DELTA_W'(term.close);
		base  = term.ring_start ? '0 : area_q;
		sum   = (AREA_W+1)'(base) + (AREA_W+1)'(delta);
		if (sum[AREA_W] != sum[AREA_W-1]) begin
			area = sum[AREA_W] ? AREA_MIN : AREA_MAX;
		end else begin
			area = sum[AREA_W-1:0];
		end

		sign     = area[AREA_W-1] ? SIGN_NEG : SIGN_POS;
		kept     = 1'b0;
		starts   = 1'b0;
		num      = '0;
		outer_nx = outer_sign_q;
		poly_nx  = poly_cnt_q;
		if (at_feature_start_q && term.feature_end) begin
			kept   = 1'b1;
			starts = 1'b1;
		end else if (area != '0) begin
			kept = 1'b1;
			if (outer_sign_q == SIGN_UNSET) begin
				outer_nx = sign;
				poly_nx  = '0;
				starts   = 1'b1;
			end else if (sign == outer_sign_q) begin
				if (({1'b0, poly_cnt_q} + (POLY_W+1)'(1)) < CAP_W) begin
					poly_nx = poly_cnt_q + POLY_W'(1);
				end
				starts = 1'b1;
			end
			num = poly_nx;
		end
		if (term.feature_end) begin
			outer_nx = SIGN_UNSET;
			poly_nx  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q             <= '0;
			at_feature_start_q <= 1'b1;
			outer_sign_q       <= SIGN_UNSET;
			poly_cnt_q         <= '0;
			out_valid_q        <= 1'b0;
		end else begin
			if (take) begin
				area_q <= area;
				if (term.ring_end) begin
					at_feature_start_q <= term.feature_end;
					outer_sign_q       <= outer_nx;
					poly_cnt_q         <= poly_nx;
				end
			end
			if (take && term.ring_end) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && term.ring_end) begin
			res_q.ring_area      <= area;
			res_q.ring_kept      <= kept;
			res_q.starts_polygon <= starts;
			res_q.polygon_number <= num;
			res_q.feature_done   <= term.feature_end;
		end
	end

endmodule

`default_nettype wire

// File: src/prc_checker.sv
// Port-level checks on result beats of the polygon ring classifier, and its bind.
`default_nettype none

module prc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_ready,
	input prc_pkg::res_t res_data
);
	import prc_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result beat changed while stalled");

	a_start_kept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.starts_polygon |-> res_data.ring_kept)
		else $error("polygon start on a dropped ring");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.ring_kept |->
			res_data.ring_area == '0 && !res_data.starts_polygon &&
			res_data.polygon_number == '0)
		else $error("dropped ring with nonzero area or polygon fields");

	a_zero_kept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.ring_kept && res_data.ring_area == '0 |->
			res_data.starts_polygon && res_data.polygon_number == '0 &&
			res_data.feature_done)
		else $error("kept zero-area ring is not a lone ring");

endmodule

bind polygon_ring_classifier prc_checker u_prc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_data  (results.data)
);

`default_nettype wire
